FILE: rtl/serial_reply_frame_parser_macros.svh
// Assertion macros shared by the frame parser checker.
`ifndef SERIAL_REPLY_FRAME_PARSER_MACROS_SVH
`define SERIAL_REPLY_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication that is checked through reset as well.
`define SRFP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

FILE: rtl/srfp_pkg.sv
// Package of types and constants for the serial reply frame parser.
package srfp_pkg;

    localparam logic [7:0] HDR_FIRST       = 8'h57;
    localparam logic [7:0] HDR_SECOND      = 8'hAB;
    localparam logic [7:0] INFO_CODE_RESET = 8'd129;
    localparam int unsigned CAP_DEPTH      = 3;
    localparam logic [1:0] CAP_FULL        = 2'd3;
    localparam int unsigned NUM_BIT        = 0;
    localparam int unsigned CAPS_BIT       = 1;
    localparam int unsigned SCROLL_BIT     = 2;

    typedef enum logic [2:0] {
        PH_H1   = 3'd0,
        PH_H2   = 3'd1,
        PH_ADDR = 3'd2,
        PH_CMD  = 3'd3,
        PH_LEN  = 3'd4,
        PH_DATA = 3'd5,
        PH_SUM  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_GOOD     = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_SYNC_ERR = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] last_command;
        logic [7:0] chip_version;
        logic [7:0] link_state;
        logic       num_lock;
        logic       caps_lock;
        logic       scroll_lock;
    } t_result;

endpackage

FILE: rtl/srfp_if.sv
// Valid/ready channel interfaces for received bytes and parse results.
interface srfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface srfp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] last_command;
    logic [7:0] chip_version;
    logic [7:0] link_state;
    logic       num_lock;
    logic       caps_lock;
    logic       scroll_lock;

    modport source (output valid, output status, output last_command, output chip_version,
                    output link_state, output num_lock, output caps_lock,
                    output scroll_lock, input ready);
    modport sink (input valid, input status, input last_command, input chip_version,
                  input link_state, input num_lock, input caps_lock, input scroll_lock,
                  output ready);
endinterface

FILE: rtl/serial_reply_frame_parser.sv
// Top level of the serial reply frame parser.
//
// Received serial bytes arrive one item at a time on the i_in channel
// (valid/ready). Each accepted byte yields exactly one result item on the
// o_out channel: a status code (frame in progress, good frame end, checksum
// mismatch, header sync error), the command byte of the current or last
// frame, and the version, link state and lock indicators latched from the
// last good info reply.
// The byte passes an input register, then the frame state machine and the
// result register. Its result item is loaded into the result register when
// the parser takes the byte from the input register. One byte is taken every
// cycle while the receiver does not stall; the rate is set by the single state
// update of the frame state machine per byte.
// When the receiver stalls, the result register holds its item and the
// input register holds the next byte; input ready drops only when both are
// full. The info reply command code is written through i_cfg_we and i_cfg_wdata;
// the user must do so only while the block is idle; the block does not check it.
// Synchronous reset empties both registers, returns the parser to header
// search, clears the latched fields and sets the info reply code to 129.
module serial_reply_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    srfp_in_if.sink    i_in,
    srfp_out_if.source o_out
);
    import srfp_pkg::*;

    logic    in_valid;
    logic [7:0] in_byte;
    logic    out_free;
    logic    step;
    t_result core_result;
    t_result out_result;

    // The parser advances whenever a byte is held and the result slot is free.
    assign step = in_valid && out_free;

    srfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.rx_byte),
        .i_take  (step),
        .o_ready (i_in.ready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    srfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_result    (core_result)
    );

    srfp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_ready  (o_out.ready),
        .o_free   (out_free),
        .o_valid  (o_out.valid),
        .o_result (out_result)
    );

    assign o_out.status       = out_result.status;
    assign o_out.last_command = out_result.last_command;
    assign o_out.chip_version = out_result.chip_version;
    assign o_out.link_state   = out_result.link_state;
    assign o_out.num_lock     = out_result.num_lock;
    assign o_out.caps_lock    = out_result.caps_lock;
    assign o_out.scroll_lock  = out_result.scroll_lock;
endmodule

FILE: rtl/srfp_in_stage.sv
// Input register that holds one received byte until the parser takes it.
module srfp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    // The register can load whenever it is empty or drains in this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end
endmodule

FILE: rtl/srfp_core.sv
// Frame state machine: header sync, checksum, data capture and info latches.
module srfp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output srfp_pkg::t_result o_result
);
    import srfp_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_sum, n_sum;
    logic [1:0] r_pos, n_pos;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_info_code;
    logic [7:0] r_cap [CAP_DEPTH];
    logic [7:0] r_version, n_version;
    logic [7:0] r_link, n_link;
    logic [2:0] r_lock, n_lock;
    logic       cap_we;
    t_status    status;
    logic [7:0] sum_add;
    logic [7:0] rem_dec;

    assign sum_add = r_sum + i_byte;
    assign rem_dec = r_rem - 8'd1;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_H1:   n_phase = (i_byte == HDR_FIRST) ? PH_H2 : PH_H1;
            PH_H2:   n_phase = (i_byte == HDR_SECOND) ? PH_ADDR : PH_H1;
            PH_ADDR: n_phase = PH_CMD;
            PH_CMD:  n_phase = PH_LEN;
            PH_LEN:  n_phase = (i_byte == 8'd0) ? PH_SUM : PH_DATA;
            PH_DATA: n_phase = (rem_dec == 8'd0) ? PH_SUM : PH_DATA;
            PH_SUM:  n_phase = PH_H1;
            default: n_phase = PH_H1;
        endcase
    end

    // Datapath updates and status for the byte in hand.
    always_comb begin
        status    = ST_BUSY;
        n_sum     = r_sum;
        n_rem     = r_rem;
        n_pos     = r_pos;
        n_cmd     = r_cmd;
        n_version = r_version;
        n_link    = r_link;
        n_lock    = r_lock;
        cap_we    = 1'b0;
        case (r_phase)
            PH_H1: begin
                if (i_byte == HDR_FIRST) begin
                    n_sum = i_byte;
                end else begin
                    status = ST_SYNC_ERR;
                end
            end
            PH_H2: begin
                if (i_byte == HDR_SECOND) begin
                    n_sum = sum_add;
                end else begin
                    status = ST_SYNC_ERR;
                end
            end
            PH_ADDR: begin
                n_sum = sum_add;
            end
            PH_CMD: begin
                n_sum = sum_add;
                n_cmd = i_byte;
            end
            PH_LEN: begin
                n_sum = sum_add;
                n_rem = i_byte;
                n_pos = 2'd0;
            end
            PH_DATA: begin
                n_sum = sum_add;
                n_rem = rem_dec;
                if (r_pos != CAP_FULL) begin
                    cap_we = 1'b1;
                    n_pos  = r_pos + 2'd1;
                end
            end
            PH_SUM: begin
                n_rem = 8'd0;
                if (i_byte == r_sum) begin
                    status = ST_GOOD;
                    // Only a full info reply updates the latched fields.
                    if (r_cmd == r_info_code && r_pos == CAP_FULL) begin
                        n_version = r_cap[0];
                        n_link    = r_cap[1];
                        n_lock    = r_cap[2][2:0];
                    end
                end else begin
                    status = ST_BAD_SUM;
                end
            end
            default: begin
                status = ST_SYNC_ERR;
                n_rem  = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_H1;
            r_rem     <= 8'd0;
            r_sum     <= 8'd0;
            r_pos     <= 2'd0;
            r_cmd     <= 8'd0;
            r_version <= 8'd0;
            r_link    <= 8'd0;
            r_lock    <= 3'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_rem     <= n_rem;
            r_sum     <= n_sum;
            r_pos     <= n_pos;
            r_cmd     <= n_cmd;
            r_version <= n_version;
            r_link    <= n_link;
            r_lock    <= n_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info_code <= INFO_CODE_RESET;
        end else if (i_cfg_we) begin
            r_info_code <= i_cfg_wdata;
        end
    end

    // Capture storage has no reset; entries are read only after being written.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAP_DEPTH; i++) begin
            if (i_step && cap_we && r_pos == 2'(i)) begin
                r_cap[i] <= i_byte;
            end
        end
    end

    always_comb begin
        o_result.status       = status;
        o_result.last_command = n_cmd;
        o_result.chip_version = n_version;
        o_result.link_state   = n_link;
        o_result.num_lock     = n_lock[NUM_BIT];
        o_result.caps_lock    = n_lock[CAPS_BIT];
        o_result.scroll_lock  = n_lock[SCROLL_BIT];
    end
endmodule

FILE: rtl/srfp_out_stage.sv
// Result register that holds one parse result until the receiver takes it.
module srfp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  srfp_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output srfp_pkg::t_result o_result
);
    import srfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule

FILE: rtl/srfp_checker.sv
// Port-level checker for the serial reply frame parser, with its bind.
`include "serial_reply_frame_parser_macros.svh"

module srfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_status,
    input logic [7:0] i_out_command
);
    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // A stalled result item keeps its status and command.
    `SRFP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_status) && $stable(i_out_command))

    // Reset empties the result register.
    `SRFP_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

    // Input backpressure appears only when a result is stuck at the output.
    `SRFP_ASSERT_IMP(a_ready_cause, i_clk, i_rst_n, !i_in_ready,
        i_out_valid && !i_out_ready)

    // An accepted byte reaches the output via the input and result registers if nothing stalls.
    `SRFP_ASSERT_NXT(a_latency, i_clk, i_rst_n,
        in_acc ##1 (!i_out_valid || i_out_ready), i_out_valid)
endmodule

bind serial_reply_frame_parser srfp_checker u_srfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_command (o_out.last_command)
);
